/* design/jvl_pkg.sv */
// jvl_pkg: shared types, constants and stream packing for the joint velocity
// limiter / integrator. No dependencies; used by every module in design/.
package jvl_pkg;

  // default number of joint stores
  localparam int MAX_JOINTS_DEF = 8;

  // fixed field widths
  localparam int JOINT_W  = 3;
  localparam int POS_W    = 32;
  localparam int VEL_W    = 20;
  localparam int DT_W     = 20;
  localparam int DELTA_W  = 21;
  localparam int COUNT_W  = 4;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_JOINTS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STEP = 1'd1;

  localparam logic [COUNT_W-1:0] NUM_JOINTS_RST   = 4'd1;
  localparam logic [DT_W-1:0]    DEFAULT_STEP_RST = 20'd1049;

  // request kinds
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_SYNC   = 1'b1;

  // arithmetic constants (Q16.16, time in 2^-20 s)
  localparam int VEL_MAX    = 393216;
  localparam int MARGIN     = 3277;
  localparam int ACCEL_NUM  = 30;
  localparam int ACCEL_SHIFT = 4;
  localparam int TIME_SHIFT = 20;

  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 56;

  typedef struct packed {
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic                    lo_en;
    logic                    hi_en;
  } limit_t;

  // input tdata, first field in the lowest bits
  typedef struct packed {
    logic [6:0]              pad;
    logic [DT_W-1:0]         step_time;
    logic                    upper_enabled;
    logic                    lower_enabled;
    logic signed [POS_W-1:0] upper_limit;
    logic signed [POS_W-1:0] lower_limit;
    logic signed [POS_W-1:0] measured_position;
    logic signed [POS_W-1:0] vel_cmd;
    logic [JOINT_W-1:0]      joint_index;
  } in_item_t;

  typedef struct packed {
    logic                    pad;
    logic signed [VEL_W-1:0] velocity_out;
    logic signed [POS_W-1:0] target_position;
    logic [JOINT_W-1:0]      joint_out;
  } out_item_t;

endpackage

/* design/jvl_limit.sv */
// jvl_limit: slew limit, velocity clamp and limit-margin zeroing of one command.
// Combinational; depends on jvl_pkg.
module jvl_limit (
  input  logic signed [jvl_pkg::POS_W-1:0]   cmd,
  input  logic signed [jvl_pkg::VEL_W-1:0]   last,
  input  logic        [jvl_pkg::DELTA_W-1:0] delta,
  input  logic signed [jvl_pkg::POS_W-1:0]   pos,
  input  jvl_pkg::limit_t                    lim,
  output logic signed [jvl_pkg::VEL_W-1:0]   vel
);

  localparam int WW = jvl_pkg::POS_W + 1;
  localparam logic signed [WW-1:0] VmaxW   = WW'(jvl_pkg::VEL_MAX);
  localparam logic signed [WW-1:0] VminW   = -WW'(jvl_pkg::VEL_MAX);
  localparam logic signed [WW-1:0] MarginW = WW'(jvl_pkg::MARGIN);

  logic signed [WW-1:0] last_x, delta_x, cmd_x, pos_x, lo_x, hi_x;
  logic signed [WW-1:0] bound_lo, bound_hi, v_a, v_b, v_c, lo_m, hi_m;
  logic signed [jvl_pkg::VEL_W-1:0] v_sat;
  logic near_lo, near_hi;

  always_comb begin
    last_x  = {{(WW-jvl_pkg::VEL_W){last[jvl_pkg::VEL_W-1]}}, last};
    delta_x = {{(WW-jvl_pkg::DELTA_W){1'b0}}, delta};
    cmd_x   = {cmd[jvl_pkg::POS_W-1], cmd};
    pos_x   = {pos[jvl_pkg::POS_W-1], pos};
    lo_x    = {lim.lo[jvl_pkg::POS_W-1], lim.lo};
    hi_x    = {lim.hi[jvl_pkg::POS_W-1], lim.hi};

    bound_lo = last_x - delta_x;
    bound_hi = last_x + delta_x;
    v_a = (cmd_x < bound_lo) ? bound_lo : cmd_x;
    v_b = (v_a > bound_hi) ? bound_hi : v_a;
    v_c = (v_b > VmaxW) ? VmaxW : ((v_b < VminW) ? VminW : v_b);
    v_sat = v_c[jvl_pkg::VEL_W-1:0];

    // stop motion heading out of an enabled limit once inside the margin
    lo_m = lo_x + MarginW;
    hi_m = hi_x - MarginW;
    near_lo = lim.lo_en && (pos_x <= lo_m) && v_sat[jvl_pkg::VEL_W-1];
    near_hi = lim.hi_en && (pos_x >= hi_m) && !v_sat[jvl_pkg::VEL_W-1] && (v_sat != '0);
    vel = (near_lo || near_hi) ? '0 : v_sat;
  end

endmodule

/* design/jvl_integrate.sv */
// jvl_integrate: integrates velocity times step time into the target,
// saturates to 32 bits and clamps to the enabled limits. Depends on jvl_pkg.
module jvl_integrate (
  input  logic signed [jvl_pkg::VEL_W-1:0] vel,
  input  logic        [jvl_pkg::DT_W-1:0]  dt,
  input  logic signed [jvl_pkg::POS_W-1:0] target,
  input  jvl_pkg::limit_t                  lim,
  output logic signed [jvl_pkg::POS_W-1:0] target_next
);

  localparam int PW = jvl_pkg::VEL_W + jvl_pkg::DT_W + 1;
  localparam int SW = jvl_pkg::POS_W + 1;
  localparam int STEP_W = PW - jvl_pkg::TIME_SHIFT;
  localparam logic signed [PW-1:0] HalfW = PW'(1) <<< (jvl_pkg::TIME_SHIFT - 1);

  logic signed [PW-1:0] prod, rounded, shifted;
  logic signed [STEP_W-1:0] step;
  logic signed [SW-1:0] sum;
  logic signed [jvl_pkg::POS_W-1:0] t_sat, t_lo;

  always_comb begin
    prod    = vel * $signed({1'b0, dt});
    rounded = prod + HalfW;
    shifted = rounded >>> jvl_pkg::TIME_SHIFT;
    step    = shifted[STEP_W-1:0];
    sum = {target[jvl_pkg::POS_W-1], target} + {{(SW-STEP_W){step[STEP_W-1]}}, step};
    if (sum[SW-1] != sum[SW-2]) begin
      t_sat = sum[SW-1] ? {1'b1, {(jvl_pkg::POS_W-1){1'b0}}}
                        : {1'b0, {(jvl_pkg::POS_W-1){1'b1}}};
    end else begin
      t_sat = sum[jvl_pkg::POS_W-1:0];
    end
    // lower first, so upper wins on crossed limits
    t_lo = (lim.lo_en && (t_sat < lim.lo)) ? lim.lo : t_sat;
    target_next = (lim.hi_en && (t_lo > lim.hi)) ? lim.hi : t_lo;
  end

endmodule

/* design/joint_velocity_limiter_integrator.sv */
// joint_velocity_limiter_integrator: top level with item register, per-joint
// stores and result register. Depends on jvl_pkg, jvl_limit, jvl_integrate.
//
//   channel  | direction | payload
//   s_axis   | in        | tuser: req_type; tdata: joint/command/position/limits/step
//   m_axis   | out       | tdata: joint_out, target_position, velocity_out
//   cfg      | in        | cfg_we, cfg_index, cfg_data (write only)
//
// One item per cycle while the result side does not stall; an update result is loaded
// as its item leaves the item register. The cycle is set by the store read, clamp chain
// and one 20x21 multiply in the item-register-to-result-register path; stores update on
// the edge that loads the result register. A stalled result holds the item register,
// which then holds s_axis_tready low. rst is synchronous; stores clear at once through
// valid bits, also on a joint count write.
module joint_velocity_limiter_integrator #(
  parameter int MAX_JOINTS = jvl_pkg::MAX_JOINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // joint_index, velocity command, measured_position, lower_limit, upper_limit,
  // lower_enabled, upper_enabled, step_time, zero fill
  input  logic [jvl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // joint_out, target_position, velocity_out, zero fill
  output logic [jvl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [jvl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jvl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int PW = jvl_pkg::POS_W;
  localparam int VW = jvl_pkg::VEL_W;
  localparam int ACC_W = jvl_pkg::DT_W + 5;

  // configuration
  logic [jvl_pkg::COUNT_W-1:0] num_joints;
  logic [jvl_pkg::DT_W-1:0]    default_step;
  logic count_wr;

  assign count_wr = cfg_we && (cfg_index == jvl_pkg::CFG_NUM_JOINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_joints   <= jvl_pkg::NUM_JOINTS_RST;
      default_step <= jvl_pkg::DEFAULT_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jvl_pkg::CFG_NUM_JOINTS:   num_joints   <= cfg_data[jvl_pkg::COUNT_W-1:0];
        jvl_pkg::CFG_DEFAULT_STEP: default_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: step time, slew step and joint range check at transfer
  jvl_pkg::in_item_t in_item;
  logic [jvl_pkg::DT_W-1:0]    dt_in;
  logic [ACC_W-1:0]            accel_prod;
  logic [7:0]                  count_x, count_eff;
  logic                        in_act;

  always_comb begin
    in_item = jvl_pkg::in_item_t'(s_axis_tdata);
    dt_in = (in_item.step_time != '0) ? in_item.step_time : default_step;
    if (dt_in == '0) begin
      dt_in = jvl_pkg::DT_W'(1);
    end
    accel_prod = ACC_W'(dt_in) * ACC_W'(jvl_pkg::ACCEL_NUM);
    count_x   = 8'(num_joints);
    count_eff = (count_x > 8'(MAX_JOINTS)) ? 8'(MAX_JOINTS) : count_x;
    in_act    = 8'(in_item.joint_index) < count_eff;
  end

  // item register
  logic                         s1_valid, s1_act, s1_sync, s1_go, s1_result;
  logic [jvl_pkg::JOINT_W-1:0]  s1_joint;
  logic signed [PW-1:0]         s1_cmd, s1_pos;
  jvl_pkg::limit_t              s1_lim;
  logic [jvl_pkg::DT_W-1:0]     s1_dt;
  logic [jvl_pkg::DELTA_W-1:0]  s1_delta;
  logic                         in_xfer;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s1_result     = s1_act && !s1_sync;
  assign s1_go         = s1_valid && (!s1_result || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_act     <= in_act;
      s1_sync    <= (s_axis_tuser == jvl_pkg::REQ_SYNC);
      s1_joint   <= in_item.joint_index;
      s1_cmd     <= in_item.vel_cmd;
      s1_pos     <= in_item.measured_position;
      s1_lim.lo  <= in_item.lower_limit;
      s1_lim.hi  <= in_item.upper_limit;
      s1_lim.lo_en <= in_item.lower_enabled;
      s1_lim.hi_en <= in_item.upper_enabled;
      s1_dt      <= dt_in;
      s1_delta   <= accel_prod[jvl_pkg::ACCEL_SHIFT +: jvl_pkg::DELTA_W];
    end
  end

  // per-joint stores; an entry without its valid bit reads as zero
  logic signed [VW-1:0] vel_store [MAX_JOINTS];
  logic signed [PW-1:0] tgt_store [MAX_JOINTS];
  logic [MAX_JOINTS-1:0] vel_valid, tgt_valid;
  logic [jvl_pkg::JOINT_W+IDX_W-1:0] joint_x;
  logic [IDX_W-1:0] addr;
  logic signed [VW-1:0] last_vel, vel_new;
  logic signed [PW-1:0] last_tgt, tgt_new;
  logic upd_we, sync_we;

  assign joint_x  = {{IDX_W{1'b0}}, s1_joint};
  assign addr     = joint_x[IDX_W-1:0];
  assign last_vel = vel_valid[addr] ? vel_store[addr] : '0;
  assign last_tgt = tgt_valid[addr] ? tgt_store[addr] : '0;
  assign upd_we   = s1_go && s1_result;
  assign sync_we  = s1_go && s1_act && s1_sync;

  jvl_limit u_limit (
    .cmd   (s1_cmd),
    .last  (last_vel),
    .delta (s1_delta),
    .pos   (s1_pos),
    .lim   (s1_lim),
    .vel   (vel_new)
  );

  jvl_integrate u_integrate (
    .vel         (vel_new),
    .dt          (s1_dt),
    .target      (last_tgt),
    .lim         (s1_lim),
    .target_next (tgt_new)
  );

  always_ff @(posedge clk) begin
    if (upd_we) begin
      vel_store[addr] <= vel_new;
      tgt_store[addr] <= tgt_new;
    end else if (sync_we) begin
      tgt_store[addr] <= s1_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || count_wr) begin
      vel_valid <= '0;
      tgt_valid <= '0;
    end else begin
      if (upd_we) begin
        vel_valid[addr] <= 1'b1;
      end
      if (upd_we || sync_we) begin
        tgt_valid[addr] <= 1'b1;
      end
    end
  end

  // result register
  jvl_pkg::out_item_t out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (upd_we) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_we) begin
      out_item.pad             <= 1'b0;
      out_item.joint_out       <= s1_joint;
      out_item.target_position <= tgt_new;
      out_item.velocity_out    <= vel_new;
    end
  end

  assign m_axis_tdata = out_item;

  // checks
  a_result_follows_update: assert property (@(posedge clk) disable iff (rst)
    upd_we |=> m_axis_tvalid && (m_axis_tdata[jvl_pkg::JOINT_W-1:0] == $past(s1_joint)))
    else $error("update did not load the result register");

  a_count_write_clears: assert property (@(posedge clk) disable iff (rst)
    count_wr |=> (vel_valid == '0) && (tgt_valid == '0))
    else $error("joint count write did not clear the stores");

  a_item_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_joint) && $stable(s1_cmd))
    else $error("item register changed while stalled");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !upd_we |=> !m_axis_tvalid)
    else $error("result delivered twice");

endmodule

/* tb/tb_joint_velocity_limiter_integrator.sv */
`timescale 1ns / 1ps
// tb_joint_velocity_limiter_integrator: self-checking bench for the joint velocity
// limiter / integrator, directed table then randomized phases with bursty traffic.
// Depends on jvl_pkg and joint_velocity_limiter_integrator.
module tb_joint_velocity_limiter_integrator;

  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_CYCLES     = 80;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 305;

  localparam logic UPD = jvl_pkg::REQ_UPDATE;
  localparam logic SYN = jvl_pkg::REQ_SYNC;

  localparam longint VMAX_L   = longint'(jvl_pkg::VEL_MAX);
  localparam longint MARGIN_L = longint'(jvl_pkg::MARGIN);
  localparam longint ACCEL_L  = longint'(jvl_pkg::ACCEL_NUM);
  localparam longint HALF_L   = longint'(1) <<< (jvl_pkg::TIME_SHIFT - 1);
  localparam longint T_MAX    = 64'sd2147483647;
  localparam longint T_MIN    = -64'sd2147483648;

  typedef enum {ROW_ITEM, ROW_SET_COUNT, ROW_SET_STEP} row_kind_e;
  typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  // step doubles as the register value on the write rows
  typedef struct {
    row_kind_e   kind;
    logic        req;
    logic [2:0]  joint;
    logic [31:0] cmd;
    logic [31:0] pos;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        lo_en;
    logic        hi_en;
    logic [19:0] step;
    bit          typed;
    logic [31:0] exp_target;
    logic [19:0] exp_vel;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [jvl_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [jvl_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic [jvl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [jvl_pkg::CFG_DATA_W-1:0] cfg_data;

  joint_velocity_limiter_integrator uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the joint stores and registers
  logic [jvl_pkg::COUNT_W-1:0]      joint_limit;
  logic [jvl_pkg::DT_W-1:0]         default_dt;
  logic signed [jvl_pkg::VEL_W-1:0] vel_model [jvl_pkg::MAX_JOINTS_DEF];
  logic signed [jvl_pkg::POS_W-1:0] target_model [jvl_pkg::MAX_JOINTS_DEF];

  jvl_pkg::out_item_t pending_setpoints [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;
  bit hold_finished = 1'b0;
  row_t directed [$];

  function automatic void add_row(input row_t r);
    directed.insert(directed.size(), r);
  endfunction

  function automatic void clear_joint_models();
    for (int i = 0; i < jvl_pkg::MAX_JOINTS_DEF; i++) begin
      vel_model[i] = '0;
      target_model[i] = '0;
    end
  endfunction

  function automatic int active_joints();
    return (int'(joint_limit) > jvl_pkg::MAX_JOINTS_DEF) ? jvl_pkg::MAX_JOINTS_DEF
                                                         : int'(joint_limit);
  endfunction

  // returns 1 when the item produces a setpoint; updates the shadow stores
  function automatic bit advance_joint(input logic req, input jvl_pkg::in_item_t it,
                                       output jvl_pkg::out_item_t res);
    longint dt, delta, last, v, t, lo, hi, pos;
    int j;
    res = '0;
    j = int'(it.joint_index);
    if (j >= active_joints()) return 1'b0;
    if (req == jvl_pkg::REQ_SYNC) begin
      target_model[j] = it.measured_position;
      return 1'b0;
    end
    pos = longint'($signed(it.measured_position));
    lo = longint'($signed(it.lower_limit));
    hi = longint'($signed(it.upper_limit));
    dt = (it.step_time != '0) ? longint'(it.step_time) : longint'(default_dt);
    if (dt < 1) dt = 1;
    delta = (ACCEL_L * dt) >>> jvl_pkg::ACCEL_SHIFT;
    last = longint'($signed(vel_model[j]));
    v = longint'($signed(it.vel_cmd));
    if (v < last - delta) v = last - delta;
    if (v > last + delta) v = last + delta;
    if (v > VMAX_L) v = VMAX_L;
    if (v < -VMAX_L) v = -VMAX_L;
    // no outward motion inside the margin of an enabled limit
    if (it.lower_enabled && pos <= lo + MARGIN_L && v < 0) v = 0;
    if (it.upper_enabled && pos >= hi - MARGIN_L && v > 0) v = 0;
    // round half up, then saturate to 32 bits before the limit clamps
    t = longint'($signed(target_model[j])) + ((v * dt + HALF_L) >>> jvl_pkg::TIME_SHIFT);
    if (t > T_MAX) t = T_MAX;
    if (t < T_MIN) t = T_MIN;
    if (it.lower_enabled && t < lo) t = lo;
    if (it.upper_enabled && t > hi) t = hi;
    target_model[j] = t[31:0];
    vel_model[j] = v[19:0];
    res.joint_out = it.joint_index;
    res.target_position = t[31:0];
    res.velocity_out = v[19:0];
    return 1'b1;
  endfunction

  // lets every outstanding setpoint drain and the item stage empty out
  task automatic settle_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [jvl_pkg::CFG_IDX_W-1:0] idx,
                              input logic [jvl_pkg::CFG_DATA_W-1:0] value);
    settle_pipeline();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == jvl_pkg::CFG_NUM_JOINTS) begin
      joint_limit = value[jvl_pkg::COUNT_W-1:0];
      clear_joint_models();
    end else begin
      default_dt = value[jvl_pkg::DT_W-1:0];
    end
  endtask

  task automatic send_item(input logic req, input jvl_pkg::in_item_t it,
                           input bit use_typed, input jvl_pkg::out_item_t typed_res);
    jvl_pkg::out_item_t res;
    s_axis_tdata <= it;
    s_axis_tuser <= req;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (advance_joint(req, it, res))
      pending_setpoints.insert(pending_setpoints.size(), use_typed ? typed_res : res);
    // keep offering back to back while the receiver is held off
    if (hold_request && !hold_finished) return;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  // result side: changing stall patterns plus one long hold-off
  initial begin : result_sink
    int mode_left;
    rx_mode_e mode;
    mode_left = 0;
    mode = RX_STREAM;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_finished) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_finished = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          RX_STREAM: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  always @(posedge clk) begin : setpoint_check
    jvl_pkg::out_item_t got;
    jvl_pkg::out_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_setpoints.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected setpoint: j%0d tgt %0d vel %0d", got.joint_out,
                   $signed(got.target_position), $signed(got.velocity_out));
      end else begin
        want = pending_setpoints.pop_front();
        if (got.joint_out !== want.joint_out || got.target_position !== want.target_position
            || got.velocity_out !== want.velocity_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("setpoint mismatch: want j%0d tgt %0d vel %0d, got j%0d tgt %0d vel %0d",
                     want.joint_out, $signed(want.target_position),
                     $signed(want.velocity_out), got.joint_out,
                     $signed(got.target_position), $signed(got.velocity_out));
        end
      end
    end
  end

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [jvl_pkg::CFG_DATA_W-1:0] phase_count [N_PHASES];
    logic [jvl_pkg::CFG_DATA_W-1:0] phase_step [N_PHASES];
    jvl_pkg::in_item_t it;
    jvl_pkg::out_item_t typed_res;
    row_t r;
    logic req;
    int eff, counted, lo_v, hi_v, pos_v;

    phase_count = '{20'd8, 20'd3, 20'd15, 20'd1, 20'd6, 20'd8};
    phase_step = '{20'd1049, 20'd1048575, 20'd1, 20'd0, 20'd333, 20'd20000};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    joint_limit = jvl_pkg::NUM_JOINTS_RST;
    default_dt = jvl_pkg::DEFAULT_STEP_RST;
    clear_joint_models();

    // after reset: one joint, default step 1049
    add_row('{ROW_ITEM, UPD, 3'd0, '0, '0, '0, '0, 1'b0, 1'b0, 20'd16,
              1'b1, 32'h0, 20'h0});
    // joint beyond the count is dropped
    add_row('{ROW_ITEM, UPD, 3'd1, 32'h00010000, '0, '0, '0, 1'b0, 1'b0,
              20'd16, 1'b0, '0, '0});
    add_row('{ROW_ITEM, SYN, 3'd0, '0, 32'h7FFFFFFF, '0, '0, 1'b0, 1'b0,
              20'd16, 1'b0, '0, '0});
    add_row('{ROW_ITEM, UPD, 3'd0, 32'h7FFFFFFF, '0, '0, '0, 1'b0, 1'b0,
              20'd16, 1'b1, 32'h7FFFFFFF, 20'd30});
    // full step time: velocity pinned at +6, target saturates
    add_row('{ROW_ITEM, UPD, 3'd0, 32'h7FFFFFFF, '0, '0, '0, 1'b0, 1'b0,
              20'hFFFFF, 1'b1, 32'h7FFFFFFF, 20'h60000});
    add_row('{ROW_ITEM, UPD, 3'd0, 32'h80000000, '0, '0, '0, 1'b0, 1'b0,
              20'd0, 1'b0, '0, '0});
    add_row('{ROW_SET_COUNT, UPD, 3'd0, '0, '0, '0, '0, 1'b0, 1'b0, 20'd8,
              1'b0, '0, '0});
    // zero default step falls back to one unit
    add_row('{ROW_SET_STEP, UPD, 3'd0, '0, '0, '0, '0, 1'b0, 1'b0, 20'd0,
              1'b0, '0, '0});
    add_row('{ROW_ITEM, UPD, 3'd7, 32'h80000000, '0, '0, '0, 1'b0, 1'b0,
              20'd0, 1'b1, 32'h0, 20'hFFFFF});
    add_row('{ROW_ITEM, SYN, 3'd7, '0, 32'h80000000, '0, '0, 1'b0, 1'b0,
              20'd0, 1'b0, '0, '0});
    add_row('{ROW_ITEM, UPD, 3'd7, 32'h80000000, '0, '0, '0, 1'b0, 1'b0,
              20'hFFFFF, 1'b1, 32'h80000000, 20'hA0000});
    // at the lower limit moving down
    add_row('{ROW_ITEM, UPD, 3'd2, 32'hFFF00000, 32'hFFFF0000, 32'hFFFF0000,
              32'h00010000, 1'b1, 1'b0, 20'h10000, 1'b0, '0, '0});
    // exactly at the upper margin, then one lsb outside it
    add_row('{ROW_ITEM, UPD, 3'd3, 32'h00100000, 32'h0000F333, '0,
              32'h00010000, 1'b0, 1'b1, 20'h10000, 1'b0, '0, '0});
    add_row('{ROW_ITEM, UPD, 3'd3, 32'h00100000, 32'h0000F332, '0,
              32'h00010000, 1'b0, 1'b1, 20'h10000, 1'b0, '0, '0});
    // crossed limits: upper wins
    add_row('{ROW_ITEM, UPD, 3'd4, '0, '0, 32'd1000, 32'hFFFFFC18, 1'b1,
              1'b1, 20'd16, 1'b1, 32'hFFFFFC18, 20'h0});
    add_row('{ROW_ITEM, UPD, 3'd5, '0, 32'h40000000, 32'd5000, '0, 1'b1,
              1'b0, 20'd16, 1'b1, 32'd5000, 20'h0});
    add_row('{ROW_ITEM, UPD, 3'd6, 32'h7FFFFFFF, 32'h80000000, '0,
              32'h80000000, 1'b0, 1'b1, 20'd16, 1'b1, 32'h80000000, 20'h0});
    add_row('{ROW_ITEM, UPD, 3'd6, 32'h80000000, 32'h7FFFFFFF,
              32'h7FFFFFFF, '0, 1'b1, 1'b0, 20'd16, 1'b1, 32'h7FFFFFFF, 20'h0});
    add_row('{ROW_ITEM, SYN, 3'd1, '0, 32'h12345678, '0, '0, 1'b0, 1'b0,
              20'd16, 1'b0, '0, '0});
    add_row('{ROW_ITEM, UPD, 3'd1, '0, '0, '0, '0, 1'b0, 1'b0, 20'd16,
              1'b1, 32'h12345678, 20'h0});
    // count of zero disables every joint
    add_row('{ROW_SET_COUNT, UPD, 3'd0, '0, '0, '0, '0, 1'b0, 1'b0, 20'd0,
              1'b0, '0, '0});
    add_row('{ROW_ITEM, UPD, 3'd0, 32'h00010000, '0, '0, '0, 1'b0, 1'b0,
              20'd16, 1'b0, '0, '0});
    add_row('{ROW_ITEM, SYN, 3'd0, '0, 32'h00050000, '0, '0, 1'b0, 1'b0,
              20'd16, 1'b0, '0, '0});
    // count above the store depth saturates
    add_row('{ROW_SET_COUNT, UPD, 3'd0, '0, '0, '0, '0, 1'b0, 1'b0, 20'd15,
              1'b0, '0, '0});
    add_row('{ROW_SET_STEP, UPD, 3'd0, '0, '0, '0, '0, 1'b0, 1'b0,
              20'hFFFFF, 1'b0, '0, '0});
    add_row('{ROW_ITEM, UPD, 3'd7, 32'h00050000, 32'hFFFF8000, 32'hFFFF0000,
              32'h00020000, 1'b1, 1'b1, 20'd0, 1'b0, '0, '0});
    add_row('{ROW_ITEM, UPD, 3'd7, 32'hFFFB0000, 32'hFFFF8000, 32'hFFFF0000,
              32'h00020000, 1'b1, 1'b1, 20'd0, 1'b0, '0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      r = directed[i];
      case (r.kind)
        ROW_SET_COUNT: set_register(jvl_pkg::CFG_NUM_JOINTS, r.step);
        ROW_SET_STEP:  set_register(jvl_pkg::CFG_DEFAULT_STEP, r.step);
        default: begin
          it = '0;
          it.joint_index = r.joint;
          it.vel_cmd = r.cmd;
          it.measured_position = r.pos;
          it.lower_limit = r.lo;
          it.upper_limit = r.hi;
          it.lower_enabled = r.lo_en;
          it.upper_enabled = r.hi_en;
          it.step_time = r.step;
          typed_res = '0;
          typed_res.joint_out = r.joint;
          typed_res.target_position = r.exp_target;
          typed_res.velocity_out = r.exp_vel;
          send_item(r.req, it, r.typed, typed_res);
        end
      endcase
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_register(jvl_pkg::CFG_NUM_JOINTS, phase_count[p]);
      set_register(jvl_pkg::CFG_DEFAULT_STEP, phase_step[p]);
      eff = active_joints();
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = '0;
        req = ($urandom_range(0, 99) < 12) ? SYN : UPD;
        if ($urandom_range(0, 99) < 6) it.joint_index = 3'($urandom_range(0, 7));
        else it.joint_index = 3'($urandom_range(0, eff - 1));
        if ($urandom_range(0, 19) == 0) begin
          lo_v = int'($urandom);
          hi_v = int'($urandom);
        end else begin
          lo_v = int'($urandom_range(0, 1572864)) - 786432;
          hi_v = lo_v + int'($urandom_range(0, 600000));
          if ($urandom_range(0, 29) == 0) hi_v = lo_v - int'($urandom_range(1, 5000));
        end
        // mostly near a limit so the margin logic sees both sides
        case ($urandom_range(0, 4))
          0: pos_v = lo_v + int'($urandom_range(0, 8000)) - 4000;
          1: pos_v = hi_v + int'($urandom_range(0, 8000)) - 4000;
          2: pos_v = int'($urandom);
          default: pos_v = lo_v + int'($urandom_range(0, 600000));
        endcase
        it.vel_cmd = ($urandom_range(0, 9) == 0) ? int'($urandom)
                     : int'($urandom_range(0, 1048576)) - 524288;
        it.measured_position = pos_v;
        it.lower_limit = lo_v;
        it.upper_limit = hi_v;
        it.lower_enabled = 1'($urandom_range(0, 1));
        it.upper_enabled = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0: it.step_time = '0;
          1: it.step_time = 20'($urandom_range(0, 20'hFFFFF));
          default: it.step_time = 20'($urandom_range(1, 40000));
        endcase
        if (p == 0 && counted == 100) hold_request = 1'b1;
        if (int'(it.joint_index) < eff) counted++;
        send_item(req, it, 1'b0, '0);
      end
    end

    settle_pipeline();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
